// ----- sv/rc_pkg.sv -----
// ----------------------------------------------------------------------------
// rc_pkg: radix converter shared types and constants
// Field widths, divider geometry, register indexes and base clamping.
// ----------------------------------------------------------------------------
package rc_pkg;

    localparam int VALUE_W       = 40;
    localparam int NUMBER_W      = 31;
    localparam int BASE_W        = 5;
    localparam int DIGIT_W       = 4;
    localparam int DEC_RADIX     = 10;
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic CFG_SOURCE_BASE = 1'b0;
    localparam logic CFG_TARGET_BASE = 1'b1;

    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);
    localparam logic [BASE_W-1:0] SRC_RESET  = BASE_W'(10);
    localparam logic [BASE_W-1:0] TGT_RESET  = BASE_W'(2);

    typedef struct packed {
        logic                start;
        logic [VALUE_W-1:0]  dividend;
        logic [BASE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [VALUE_W-1:0]  quotient;
        logic [DIGIT_W-1:0]  remainder;
    } div_rsp_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN)
        begin
            r = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            r = BASE_MAX;
        end
        return r;
    endfunction

endpackage

// ----- sv/rc_ram.sv -----
// ----------------------------------------------------------------------------
// rc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/rc_div_unit.sv -----
// ----------------------------------------------------------------------------
// rc_div_unit: shared iterative divider
// Restoring division of a 40-bit value by a small divisor, eight quotient
// bits per cycle; quotient and remainder are valid in the done cycle.
// ----------------------------------------------------------------------------
module rc_div_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  rc_pkg::div_req_t req,
    output rc_pkg::div_rsp_t rsp
);
    import rc_pkg::*;

    logic [VALUE_W-1:0] acc_reg,  acc_next;
    logic [DIGIT_W-1:0] rem_reg,  rem_next;
    logic [BASE_W-1:0]  dvs_reg,  dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [VALUE_W-1:0] a;
    logic [BASE_W-1:0]  r;

    always_comb
    begin
        a = acc_reg;
        r = BASE_W'(rem_reg);
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            r = {r[BASE_W-2:0], a[VALUE_W-1]};
            a = {a[VALUE_W-2:0], 1'b0};
            if (r >= dvs_reg)
            begin
                r    = r - dvs_reg;
                a[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg)
        begin
            acc_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = a;
            rem_next  = r[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= BASE_MIN;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = acc_reg;
    assign rsp.remainder = rem_reg;

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while still busy");

    a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (BASE_W'(rem_reg) < dvs_reg))
        else $error("remainder not below divisor");

endmodule

// ----- sv/radix_converter_top.sv -----
// ----------------------------------------------------------------------------
// radix_converter_top: decimal-digit reinterpreting radix converter
// Decimal digits are peeled off and target digits produced by successive
//   divisions on the one shared 8-bit-per-cycle divider; digits then leave
//   the digit RAM one at a time, most significant first, waiting while
//   out_ready holds the output register.
// A new request is taken once the final digit sits in the output register.
// Reset: bases return to 10 and 2, sequencer and output go idle.
// ----------------------------------------------------------------------------
module radix_converter_top #(
    parameter int DECIMAL_DIGITS = 10,
    parameter int MAX_OUT_DIGITS = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [rc_pkg::BASE_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rc_pkg::NUMBER_W-1:0]   number_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rc_pkg::DIGIT_W-1:0]    digit,
    output logic                          last
);
    import rc_pkg::*;

    localparam int DEC_CNT_W = $clog2(DECIMAL_DIGITS + 1);
    localparam int CNT_W     = $clog2(MAX_OUT_DIGITS + 1);
    localparam int ADDR_W    = $clog2(MAX_OUT_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC_START,
        S_DEC_WAIT,
        S_CONV_CHK,
        S_CONV_WAIT,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t                state_reg,   state_next;
    logic [BASE_W-1:0]     src_base_reg, src_base_next;
    logic [BASE_W-1:0]     tgt_base_reg, tgt_base_next;
    logic [BASE_W-1:0]     sb_reg,      sb_next;
    logic [BASE_W-1:0]     tb_reg,      tb_next;
    logic [NUMBER_W-1:0]   num_reg,     num_next;
    logic [VALUE_W-1:0]    value_reg,   value_next;
    logic [VALUE_W-1:0]    weight_reg,  weight_next;
    logic [DEC_CNT_W-1:0]  dec_cnt_reg, dec_cnt_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic [ADDR_W-1:0]     emit_idx_reg, emit_idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]    digit_reg,   digit_next;
    logic                  last_reg,    last_next;

    div_req_t              req;
    div_rsp_t              rsp;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [DIGIT_W-1:0]    ram_wr_data;
    logic                  ram_rd_en;
    logic [DIGIT_W-1:0]    ram_rd_data;

    rc_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_OUT_DIGITS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (emit_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        src_base_next  = src_base_reg;
        tgt_base_next  = tgt_base_reg;
        sb_next        = sb_reg;
        tb_next        = tb_reg;
        num_next       = num_reg;
        value_next     = value_reg;
        weight_next    = weight_reg;
        dec_cnt_next   = dec_cnt_reg;
        cnt_next       = cnt_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        req.start      = 1'b0;
        req.dividend   = value_reg;
        req.divisor    = tb_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cnt_reg[ADDR_W-1:0];
        ram_wr_data    = rsp.remainder;
        ram_rd_en      = 1'b0;

        if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SOURCE_BASE: src_base_next = cfg_wdata;
                CFG_TARGET_BASE: tgt_base_next = cfg_wdata;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next     = number_in;
                    value_next   = '0;
                    weight_next  = VALUE_W'(1);
                    dec_cnt_next = '0;
                    sb_next      = clamp_base(src_base_reg);
                    tb_next      = clamp_base(tgt_base_reg);
                    state_next   = S_DEC_START;
                end
            end
            S_DEC_START:
            begin
                if (num_reg == '0 || dec_cnt_reg == DEC_CNT_W'(DECIMAL_DIGITS))
                begin
                    cnt_next   = '0;
                    state_next = S_CONV_CHK;
                end
                else
                begin
                    req.start    = 1'b1;
                    req.dividend = VALUE_W'(num_reg);
                    req.divisor  = BASE_W'(DEC_RADIX);
                    state_next   = S_DEC_WAIT;
                end
            end
            S_DEC_WAIT:
            begin
                if (rsp.done)
                begin
                    num_next     = rsp.quotient[NUMBER_W-1:0];
                    value_next   = value_reg + VALUE_W'(rsp.remainder) * weight_reg;
                    weight_next  = weight_reg * VALUE_W'(sb_reg);
                    dec_cnt_next = dec_cnt_reg + DEC_CNT_W'(1);
                    state_next   = S_DEC_START;
                end
            end
            S_CONV_CHK:
            begin
                if (value_reg == '0 && cnt_reg == '0)
                begin
                    ram_wr_en     = 1'b1;
                    ram_wr_data   = '0;
                    cnt_next      = CNT_W'(1);
                    emit_idx_next = '0;
                    state_next    = S_EMIT_RD;
                end
                else if (value_reg == '0 || cnt_reg == CNT_W'(MAX_OUT_DIGITS))
                begin
                    emit_idx_next = ADDR_W'(cnt_reg - CNT_W'(1));
                    state_next    = S_EMIT_RD;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_CONV_WAIT;
                end
            end
            S_CONV_WAIT:
            begin
                if (rsp.done)
                begin
                    ram_wr_en  = 1'b1;
                    value_next = rsp.quotient;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_CONV_CHK;
                end
            end
            S_EMIT_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = ram_rd_data;
                    last_next      = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg - ADDR_W'(1);
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_base_reg  <= SRC_RESET;
            tgt_base_reg  <= TGT_RESET;
            sb_reg        <= SRC_RESET;
            tb_reg        <= TGT_RESET;
            num_reg       <= '0;
            value_reg     <= '0;
            weight_reg    <= '0;
            dec_cnt_reg   <= '0;
            cnt_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            digit_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_base_reg  <= src_base_next;
            tgt_base_reg  <= tgt_base_next;
            sb_reg        <= sb_next;
            tb_reg        <= tb_next;
            num_reg       <= num_next;
            value_reg     <= value_next;
            weight_reg    <= weight_next;
            dec_cnt_reg   <= dec_cnt_next;
            cnt_reg       <= cnt_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
            last_reg      <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign last      = last_reg;

    a_ram_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (cnt_reg < CNT_W'(MAX_OUT_DIGITS)))
        else $error("digit write beyond buffer");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_DEC_WAIT || state_reg == S_CONV_WAIT))
        else $error("divider result with no waiting step");

    a_idle_divider_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rsp.busy)
        else $error("divider busy while idle");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD) |-> (cnt_reg != '0))
        else $error("emitting with empty digit buffer");

endmodule
